// ----- src/pcx_pkg.sv -----
package pcx_pkg;

    // Operations of the shared bit-serial arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } pcx_op_t;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    start;
        pcx_op_t op;
    } pcx_req_t;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_D2X,
        S_D2Y,
        S_R2,
        S_TEST,
        S_CRA,
        S_CRB,
        S_CRX,
        S_SQD,
        S_EXX,
        S_EXY,
        S_SQL,
        S_DVH,
        S_HH,
        S_SQA,
        S_SQB,
        S_SCM,
        S_SCD,
        S_EMIT,
        S_FIN
    } pcx_state_t;

    localparam int RADIUS_BITS = 31;

endpackage

// ----- src/pcx_serial.sv -----
module pcx_serial #(
    parameter int H = 36
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcx_pkg::pcx_req_t  req,
    input  logic [H-1:0]       a,
    input  logic [H-1:0]       b,
    input  logic [2*H-1:0]     n,
    output logic               done,
    output logic [2*H-1:0]     res,
    output logic [H:0]         rem
);
    import pcx_pkg::*;

    localparam int W  = 2 * H;
    localparam int CW = $clog2(W + 1);

    logic            busy_reg;
    pcx_op_t         op_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    sh_reg;
    logic [H+2:0]    aux_reg;
    logic [H-1:0]    dv_reg;
    logic            done_reg;

    logic [H+2:0]    div_r;
    logic            div_ge;
    logic [H+2:0]    sq_r;
    logic [H+2:0]    sq_t;
    logic            sq_ge;
    logic            last_step;

    // One quotient bit or one root bit per cycle
    always_comb
    begin
        div_r  = {aux_reg[H+1:0], sh_reg[W-1]};
        div_ge = div_r >= {3'b000, dv_reg};
        sq_r   = {aux_reg[H:0], sh_reg[W-1:W-2]};
        sq_t   = {1'b0, acc_reg[H-1:0], 2'b01};
        sq_ge  = sq_r >= sq_t;
        case (op_reg)
            OP_DIV:  last_step = cnt_reg == CW'(W - 1);
            default: last_step = cnt_reg == CW'(H - 1);
        endcase
    end

    // Shift-add multiply, restoring divide, digit-by-digit square root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            dv_reg  <= b;
            case (req.op)
                OP_MUL:
                begin
                    sh_reg  <= W'(a);
                    aux_reg <= (H+3)'(b);
                end
                default:
                begin
                    sh_reg  <= n;
                    aux_reg <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (aux_reg[0])
                    begin
                        acc_reg <= acc_reg + sh_reg;
                    end
                    sh_reg  <= {sh_reg[W-2:0], 1'b0};
                    aux_reg <= {1'b0, aux_reg[H+2:1]};
                end
                OP_DIV:
                begin
                    if (div_ge)
                    begin
                        aux_reg <= div_r - {3'b000, dv_reg};
                    end
                    else
                    begin
                        aux_reg <= div_r;
                    end
                    sh_reg <= {sh_reg[W-2:0], div_ge};
                end
                default:
                begin
                    if (sq_ge)
                    begin
                        aux_reg <= sq_r - sq_t;
                    end
                    else
                    begin
                        aux_reg <= sq_r;
                    end
                    acc_reg <= {acc_reg[W-2:0], sq_ge};
                    sh_reg  <= {sh_reg[W-3:0], 2'b00};
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_DIV) ? sh_reg : acc_reg;
    assign rem  = aux_reg[H:0];

endmodule

// ----- src/polyline_circle_exit_point_unit.sv -----
// Work: a vertex inside the circle takes three serial multiplies with H = 64;
//   a crossing adds up to ten more multiplies or square roots and three divisions.
// Throughput: one vertex at a time; every operation shares one bit-serial unit.
// Reset: rst_n is asynchronous active low; radius returns to 256, the vertex
//   count, crossing flag and output valid clear.
module polyline_circle_exit_point_unit #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [pcx_pkg::RADIUS_BITS-1:0]         cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // cross_x, cross_y, segment_start_index
    output logic [((2*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] m_tdata,
    // found
    output logic                                    m_tuser
);
    import pcx_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int I     = INDEX_BITS;
    localparam int D     = C + 1;
    // Roots and quotients keep 64 bits; squares wrap at 128 bits
    localparam int H     = 64;
    localparam int W     = 2 * H;
    localparam int OUT_W = ((2*C+I+7)/8)*8;

    function automatic logic [H-1:0] absd(input logic [D-1:0] v);
        logic [D-1:0] m;
        m = v[D-1] ? (~v + 1'b1) : v;
        return H'(m);
    endfunction

    function automatic logic pos(input logic [D-1:0] v);
        return !v[D-1] && (v != '0);
    endfunction

    pcx_state_t     state_reg, state_next;
    logic           go_reg, go_next;
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [C-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [C-1:0]   px_reg, px_next, py_reg, py_next;
    logic [C-1:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic           last_reg, last_next;
    logic           pz_reg, pz_next;
    logic [I-1:0]   idx_reg, idx_next;
    logic           cd_reg, cd_next;
    logic           upd_reg, upd_next;
    logic [W-1:0]   d2_reg, d2_next, r2_reg, r2_next;
    logic [W-1:0]   t1_reg, t1_next, crs_reg, crs_next;
    logic [H-1:0]   den_reg, den_next, num_reg, num_next;
    logic           mode_a_reg, mode_a_next, axis_reg, axis_next;
    logic           rf_reg, rf_next;
    logic [C-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic           mv_reg, mv_next, mf_reg, mf_next;
    logic [C-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic [I-1:0]   mi_reg, mi_next;

    pcx_req_t       u_req;
    logic [H-1:0]   u_a, u_b;
    logic [W-1:0]   u_n;
    logic           u_done;
    logic [W-1:0]   u_res;
    logic [H:0]     u_rem;

    logic [D-1:0]   dx, dy, gx, gy, del;
    logic           sa, sb, del_neg;
    logic [W-1:0]   crs_w;
    logic [H-1:0]   root_a;
    logic [H-1:0]   tval;
    logic           rnd;
    logic [C-1:0]   q, off, base, coord;
    logic [I-1:0]   idx_inc;

    pcx_serial #(.H(H)) u_serial (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .a     (u_a),
        .b     (u_b),
        .n     (u_n),
        .done  (u_done),
        .res   (u_res),
        .rem   (u_rem)
    );

    // Differences, cross product and scaling terms
    always_comb
    begin
        dx = {vx_reg[C-1], vx_reg} - {cx_reg[C-1], cx_reg};
        dy = {vy_reg[C-1], vy_reg} - {cy_reg[C-1], cy_reg};
        gx = {vx_reg[C-1], vx_reg} - {px_reg[C-1], px_reg};
        gy = {vy_reg[C-1], vy_reg} - {py_reg[C-1], py_reg};
        sa = pos(dx) ^ gy[D-1];
        sb = pos(dy) ^ gx[D-1];
        if (sa != sb)
        begin
            crs_w = t1_reg + u_res;
        end
        else if (t1_reg >= u_res)
        begin
            crs_w = t1_reg - u_res;
        end
        else
        begin
            crs_w = u_res - t1_reg;
        end
        root_a = num_reg;
        if (root_a >= u_res[H-1:0])
        begin
            tval = root_a - u_res[H-1:0];
        end
        else
        begin
            tval = '0;
        end
        if (tval > den_reg)
        begin
            tval = den_reg;
        end
        if (mode_a_reg)
        begin
            del     = axis_reg ? dy : dx;
            del_neg = del[D-1];
            base    = axis_reg ? cy_reg : cx_reg;
        end
        else
        begin
            del     = axis_reg ? gy : gx;
            del_neg = pos(del);
            base    = axis_reg ? vy_reg : vx_reg;
        end
        rnd = {u_rem, 1'b0} >= (H+2)'(den_reg);
        q   = (den_reg == '0) ? '0 : (u_res[C-1:0] + C'(rnd));
        off = del_neg ? (~q + 1'b1) : q;
        coord = base + off;
        idx_inc = (idx_reg == '1) ? idx_reg : idx_reg + 1'b1;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        go_next     = go_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        last_next   = last_reg;
        pz_next     = pz_reg;
        idx_next    = idx_reg;
        cd_next     = cd_reg;
        upd_next    = upd_reg;
        d2_next     = d2_reg;
        r2_next     = r2_reg;
        t1_next     = t1_reg;
        crs_next    = crs_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        mode_a_next = mode_a_reg;
        axis_next   = axis_reg;
        rf_next     = rf_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        mv_next     = mv_reg;
        mf_next     = mf_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        mi_next     = mi_reg;
        u_req.start = 1'b0;
        u_req.op    = OP_MUL;
        u_a         = '0;
        u_b         = '0;
        u_n         = '0;
        s_tready    = 1'b0;

        // Drop the result once the sink takes it
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    vx_next   = s_tdata[C-1:0];
                    vy_next   = s_tdata[2*C-1:C];
                    last_next = s_tlast;
                    if (idx_reg == '0)
                    begin
                        cx_next = s_tdata[C-1:0];
                        cy_next = s_tdata[2*C-1:C];
                        px_next = s_tdata[C-1:0];
                        py_next = s_tdata[2*C-1:C];
                        pz_next = 1'b1;
                        cd_next = 1'b0;
                        if (s_tlast)
                        begin
                            rf_next    = 1'b0;
                            upd_next   = 1'b0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            idx_next = I'(1);
                        end
                    end
                    else if (cd_reg)
                    begin
                        idx_next = idx_inc;
                        if (s_tlast)
                        begin
                            idx_next = '0;
                            cd_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        upd_next   = 1'b1;
                        state_next = S_D2X;
                    end
                end
            end
            S_D2X:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(dx);
                u_b      = absd(dx);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    d2_next    = u_res;
                    state_next = S_D2Y;
                end
            end
            S_D2Y:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(dy);
                u_b      = absd(dy);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    d2_next    = d2_reg + u_res;
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                u_req.op = OP_MUL;
                u_a      = H'(radius_reg);
                u_b      = H'(radius_reg);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    r2_next    = u_res;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (d2_reg >= r2_reg)
                begin
                    state_next = S_CRA;
                end
                else if (last_reg)
                begin
                    rf_next    = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    px_next    = vx_reg;
                    py_next    = vy_reg;
                    pz_next    = d2_reg == '0;
                    state_next = S_FIN;
                end
            end
            S_CRA:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(dx);
                u_b      = absd(gy);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    t1_next    = u_res;
                    state_next = S_CRB;
                end
            end
            S_CRB:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(dy);
                u_b      = absd(gx);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    crs_next   = crs_w;
                    state_next = S_CRX;
                end
            end
            S_CRX:
            begin
                rf_next   = 1'b1;
                axis_next = 1'b0;
                if (pz_reg || crs_reg == '0)
                begin
                    mode_a_next = 1'b1;
                    state_next  = S_SQD;
                end
                else if (d2_reg == r2_reg)
                begin
                    ox_next    = vx_reg;
                    oy_next    = vy_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    mode_a_next = 1'b0;
                    state_next  = S_EXX;
                end
            end
            S_SQD:
            begin
                u_req.op = OP_SQRT;
                u_n      = d2_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    den_next   = u_res[H-1:0];
                    num_next   = H'(radius_reg);
                    state_next = S_SCM;
                end
            end
            S_EXX:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(gx);
                u_b      = absd(gx);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    t1_next    = u_res;
                    state_next = S_EXY;
                end
            end
            S_EXY:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(gy);
                u_b      = absd(gy);
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    t1_next    = t1_reg + u_res;
                    state_next = S_SQL;
                end
            end
            S_SQL:
            begin
                u_req.op = OP_SQRT;
                u_n      = t1_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next  = 1'b0;
                    den_next = u_res[H-1:0];
                    if (u_res[H-1:0] == '0)
                    begin
                        ox_next    = vx_reg;
                        oy_next    = vy_reg;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DVH;
                    end
                end
            end
            S_DVH:
            begin
                u_req.op = OP_DIV;
                u_n      = crs_reg;
                u_b      = den_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    num_next   = u_res[H-1:0];
                    state_next = S_HH;
                end
            end
            S_HH:
            begin
                u_req.op = OP_MUL;
                u_a      = num_reg;
                u_b      = num_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    t1_next    = u_res;
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                u_req.op = OP_SQRT;
                u_n      = d2_reg - t1_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    num_next   = u_res[H-1:0];
                    state_next = S_SQB;
                end
            end
            S_SQB:
            begin
                u_req.op = OP_SQRT;
                u_n      = r2_reg - t1_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    num_next   = tval;
                    state_next = S_SCM;
                end
            end
            S_SCM:
            begin
                u_req.op = OP_MUL;
                u_a      = absd(del);
                u_b      = num_reg;
                if (!go_reg)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (u_done)
                begin
                    go_next    = 1'b0;
                    t1_next    = u_res;
                    state_next = S_SCD;
                end
            end
            S_SCD:
            begin
                u_req.op = OP_DIV;
                u_n      = t1_reg;
                u_b      = den_reg;
                if (!go_reg && den_reg != '0)
                begin
                    u_req.start = 1'b1;
                    go_next     = 1'b1;
                end
                else if (den_reg == '0 || u_done)
                begin
                    go_next = 1'b0;
                    if (axis_reg)
                    begin
                        oy_next    = coord;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ox_next    = coord;
                        axis_next  = 1'b1;
                        state_next = S_SCM;
                    end
                end
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    mf_next = rf_reg;
                    mx_next = rf_reg ? ox_reg : '0;
                    my_next = rf_reg ? oy_reg : '0;
                    mi_next = rf_reg ? (idx_reg - 1'b1) : '0;
                    if (upd_reg)
                    begin
                        idx_next = idx_inc;
                        cd_next  = rf_reg;
                        if (last_reg)
                        begin
                            idx_next = '0;
                            cd_next  = 1'b0;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                idx_next = idx_inc;
                if (last_reg)
                begin
                    idx_next = '0;
                    cd_next  = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            go_reg     <= 1'b0;
            radius_reg <= RADIUS_BITS'(256);
            idx_reg    <= '0;
            cd_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            idx_reg   <= idx_next;
            cd_reg    <= cd_next;
            mv_reg    <= mv_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        last_reg   <= last_next;
        pz_reg     <= pz_next;
        upd_reg    <= upd_next;
        d2_reg     <= d2_next;
        r2_reg     <= r2_next;
        t1_reg     <= t1_next;
        crs_reg    <= crs_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        mode_a_reg <= mode_a_next;
        axis_reg   <= axis_next;
        rf_reg     <= rf_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        mf_reg     <= mf_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        mi_reg     <= mi_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mf_reg;
    assign m_tdata  = OUT_W'({mi_reg, my_reg, mx_reg});

endmodule

// ----- src/pcx_checker.sv -----
module pcx_checker #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input logic                                          clk,
    input logic                                          rst_n,
    input logic                                          s_tready,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((2*COORD_BITS+INDEX_BITS+7)/8)*8-1:0]  m_tdata,
    input logic                                          m_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Not-found results carry zero fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero data");

    // A new result is loaded only while input is closed
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while input open");

endmodule

bind polyline_circle_exit_point_unit pcx_checker #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_pcx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
